// File: design/bts_pkg.sv
// Block transfer sequencer package: transaction structs, result kinds,
// microcode word layout and the microcode program ROM.
// No dependencies.
`default_nettype none

package bts_pkg;

  localparam int unsigned LIST_WIDTH = 16;
  localparam logic [31:0] EMPTY_LIST_STEP = 32'h0000_0040;
  localparam logic [31:0] WORD_STEP = 32'h0000_0004;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;
  localparam logic [3:0] PC_REG = 4'd15;

  typedef enum logic [1:0] {
    KIND_XFER = 2'd0,
    KIND_WB   = 2'd1,
    KIND_PC   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [15:0] register_list;
    logic        count_up;
    logic        pre_index;
    logic        write_back;
    logic        is_load;
    logic        user_bank;
    logic [3:0]  base_register;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [3:0]  register_index;
    logic        load_access;
    logic        use_user_bank;
    logic        pc_plus_four;
    logic        override_store;
    logic [31:0] override_value;
    logic        restore_status;
    logic [4:0]  wait_cycles;
    logic        last;
  } rsp_t;

  // Micro-operations driven by one control word
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SETUP,
    OP_XFER,
    OP_WB,
    OP_EPC,
    OP_EWB
  } op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_EMPTY,
    COND_DONE
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_SETUP = 3'd1;
  localparam step_t ST_XFER  = 3'd2;
  localparam step_t ST_WB    = 3'd3;
  localparam step_t ST_EPC   = 3'd4;
  localparam step_t ST_EWB   = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump_to;
    step_t other_to;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    unique case (s)
      ST_IDLE:  c = '{op: OP_IDLE,  cond: COND_ACCEPT, jump_to: ST_SETUP, other_to: ST_IDLE};
      ST_SETUP: c = '{op: OP_SETUP, cond: COND_EMPTY,  jump_to: ST_EPC,   other_to: ST_XFER};
      ST_XFER:  c = '{op: OP_XFER,  cond: COND_DONE,   jump_to: ST_WB,    other_to: ST_XFER};
      ST_WB:    c = '{op: OP_WB,    cond: COND_ALWAYS, jump_to: ST_IDLE,  other_to: ST_IDLE};
      ST_EPC:   c = '{op: OP_EPC,   cond: COND_ALWAYS, jump_to: ST_EWB,   other_to: ST_EWB};
      ST_EWB:   c = '{op: OP_EWB,   cond: COND_ALWAYS, jump_to: ST_IDLE,  other_to: ST_IDLE};
      default:  c = '{op: OP_IDLE,  cond: COND_ALWAYS, jump_to: ST_IDLE,  other_to: ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/block_transfer_sequencer.sv
// Block transfer sequencer: load/store-multiple address sequencer driven by
// a microcode ROM from bts_pkg; emits results from transfer and writeback steps.
//
//   channel  dir  handshake            payload
//   cmd      in   cmd_valid/cmd_stall  bts_pkg::cmd_t, one instruction
//   rsp      out  rsp_valid/rsp_stall  bts_pkg::rsp_t, 1..17 per instruction
//
// An instruction steps through accept, setup, one transfer per listed
// register (one per cycle while rsp is not stalled) and a writeback; an empty
// list gives accept, setup, PC and writeback steps, sequenced by the microcode.
// cmd_stall is high while an instruction is in progress; a stalled rsp holds
// the sequencer on its current step. rst is synchronous and returns to idle.
`default_nettype none

module block_transfer_sequencer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire bts_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bts_pkg::rsp_t      rsp
);
  import bts_pkg::*;

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [2:0] nib [4];
    for (int k = 0; k < 4; k++) begin
      nib[k] = 3'({2'b0, v[4*k]} + {2'b0, v[4*k+1]}) +
               3'({2'b0, v[4*k+2]} + {2'b0, v[4*k+3]});
    end
    return 5'({2'b0, nib[0]} + {2'b0, nib[1]}) + 5'({2'b0, nib[2]} + {2'b0, nib[3]});
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int k = 0; k < 16; k++) begin
      r[k] = v[15-k];
    end
    return r;
  endfunction

  function automatic logic [3:0] encode16(input logic [15:0] oh);
    logic [3:0] idx;
    idx = '0;
    for (int k = 0; k < 16; k++) begin
      if (oh[k]) begin
        idx = idx | 4'(k);
      end
    end
    return idx;
  endfunction

  step_t       step, step_next;
  ctrl_t       ctrl;

  logic [31:0] base;
  logic [15:0] rem, rem_next;
  logic        up, pre, wb, load, sbit;
  logic [3:0]  breg;
  logic [31:0] addr, addr_next;
  logic [31:0] ovr_val;
  logic [4:0]  wait_cnt;
  logic        wb_en, base_not_first, user_sel;

  logic [31:0] addr_step;
  logic [15:0] rem_scan, sel_oh_scan, sel_oh;
  logic [3:0]  sel_reg;
  logic [4:0]  n;
  logic [31:0] total;
  logic [15:0] below_mask;
  logic [31:0] epc_off;

  logic        out_free, emit, cond_met, advance;
  rsp_t        res;

  assign ctrl      = ucode(step);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (ctrl.op != OP_IDLE);

  assign addr_step   = addr + (up ? WORD_STEP : (32'd0 - WORD_STEP));
  assign rem_scan    = up ? rem : rev16(rem);
  assign sel_oh_scan = rem_scan & (~rem_scan + 16'd1);
  assign sel_oh      = up ? sel_oh_scan : rev16(sel_oh_scan);
  assign sel_reg     = encode16(sel_oh);
  assign rem_next    = rem & ~sel_oh;

  assign n          = popcount16(rem);
  assign total      = up ? {25'd0, n, 2'b00} : (32'd0 - {25'd0, n, 2'b00});
  assign below_mask = (16'd1 << breg) - 16'd1;
  assign epc_off    = up ? (pre ? WORD_STEP : 32'd0)
                         : (pre ? (32'd0 - EMPTY_LIST_STEP)
                                : (32'd0 - (EMPTY_LIST_STEP - WORD_STEP)));

  always_comb begin
    res  = '0;
    emit = 1'b0;
    unique case (ctrl.op)
      OP_XFER: begin
        emit               = 1'b1;
        res.kind           = KIND_XFER;
        res.address        = (pre ? addr_step : addr) & WORD_MASK;
        res.register_index = sel_reg;
        res.load_access    = load;
        res.use_user_bank  = user_sel;
        res.pc_plus_four   = !load && (sel_reg == PC_REG);
        res.override_store = !load && wb && (sel_reg == breg) && base_not_first;
        res.override_value = res.override_store ? ovr_val : 32'd0;
        res.restore_status = load && sbit && (sel_reg == PC_REG);
        res.last           = (rem_next == 16'd0) && !wb_en;
        res.wait_cycles    = res.last ? wait_cnt : 5'd0;
      end
      OP_WB: begin
        emit               = wb_en;
        res.kind           = KIND_WB;
        res.address        = addr;
        res.register_index = breg;
        res.wait_cycles    = wait_cnt;
        res.last           = 1'b1;
      end
      OP_EPC: begin
        emit               = 1'b1;
        res.kind           = KIND_PC;
        res.address        = (base + epc_off) & WORD_MASK;
        res.register_index = PC_REG;
        res.load_access    = load;
        res.pc_plus_four   = !load;
      end
      OP_EWB: begin
        emit               = 1'b1;
        res.kind           = KIND_WB;
        res.address        = up ? (base + EMPTY_LIST_STEP) : (base - EMPTY_LIST_STEP);
        res.register_index = breg;
        res.wait_cycles    = 5'd1;
        res.last           = 1'b1;
      end
      OP_IDLE, OP_SETUP: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS: cond_met = 1'b1;
      COND_ACCEPT: cond_met = cmd_valid;
      COND_EMPTY:  cond_met = (rem == 16'd0);
      COND_DONE:   cond_met = (rem_next == 16'd0);
      default:     cond_met = 1'b1;
    endcase
    advance   = !emit || out_free;
    step_next = step;
    if (advance) begin
      step_next = cond_met ? ctrl.jump_to : ctrl.other_to;
    end
    addr_next = addr;
    if (ctrl.op == OP_XFER && advance) begin
      addr_next = addr_step;
    end else if (ctrl.op == OP_IDLE && cmd_valid) begin
      addr_next = cmd.base_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (emit && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (emit && out_free) begin
      rsp <= res;
    end
    unique case (ctrl.op)
      OP_IDLE: begin
        if (cmd_valid) begin
          base <= cmd.base_address;
          rem  <= cmd.register_list;
          up   <= cmd.count_up;
          pre  <= cmd.pre_index;
          wb   <= cmd.write_back;
          load <= cmd.is_load;
          sbit <= cmd.user_bank;
          breg <= cmd.base_register;
        end
      end
      OP_SETUP: begin
        ovr_val        <= base + total;
        wait_cnt       <= load ? (n + (rem[15] ? 5'd4 : 5'd2)) : (n + 5'd1);
        wb_en          <= wb && !(load && rem[breg]);
        base_not_first <= (rem & below_mask) != 16'd0;
        user_sel       <= sbit && !(load && rem[15]);
      end
      OP_XFER: begin
        if (out_free) begin
          rem <= rem_next;
        end
      end
      OP_WB, OP_EPC, OP_EWB: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
